/* design/kce_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the keyframe curve evaluator.
// No dependencies.
package kce_pkg;

  localparam int MAX_KEYS   = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DW         = 32;
  localparam int SLOT_W     = $clog2(MAX_KEYS);
  localparam int CNT_W      = $clog2(MAX_KEYS + 1);
  localparam int KEYS_W     = 5;
  localparam int NZ_W       = 16;
  localparam int EXT_W      = DW + 1;
  localparam int NUM_W      = EXT_W + FRAC_BITS;
  localparam int OPW        = EXT_W + 1;
  localparam int PROD_W     = 2 * OPW;
  localparam int SH_W       = PROD_W - FRAC_BITS;
  localparam int AW         = FRAC_BITS + 1;
  localparam int HW         = FRAC_BITS + 4;
  localparam int ACC_W      = SH_W;
  localparam int DCNT_W     = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEYS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_ZERO   = 1'd1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [1:0] INTERP_CONST  = 2'd0;
  localparam logic [1:0] INTERP_LINEAR = 2'd1;

  localparam logic [AW-1:0] ONE = AW'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [DW-1:0] t;
    logic signed [DW-1:0] v;
    logic [1:0]           interp;
    logic                 tk;
    logic signed [DW-1:0] arrive;
    logic signed [DW-1:0] leave;
  } key_t;

  function automatic logic [EXT_W-1:0] mag(input logic signed [EXT_W-1:0] d);
    mag = d[EXT_W-1] ? (~d + 1'b1) : d;
  endfunction

  function automatic logic near_zero(input logic signed [EXT_W-1:0] d,
                                     input logic [NZ_W-1:0] lim);
    near_zero = (d == '0) || (mag(d) < EXT_W'(lim));
  endfunction

  function automatic logic signed [DW-1:0] sat_div(input logic [NUM_W-1:0] q,
                                                   input logic neg);
    logic [NUM_W-1:0] lim_pos;
    logic [NUM_W-1:0] lim_neg;
    lim_pos = NUM_W'(32'h7fff_ffff);
    lim_neg = NUM_W'(32'h8000_0000);
    if (!neg) begin
      sat_div = (q > lim_pos) ? 32'sh7fff_ffff : q[DW-1:0];
    end else begin
      sat_div = (q > lim_neg) ? 32'sh8000_0000 : (~q[DW-1:0] + 1'b1);
    end
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [SH_W-1:0] x);
    if (x[SH_W-1:DW-1] == '0 || x[SH_W-1:DW-1] == '1) begin
      sat32 = x[DW-1:0];
    end else begin
      sat32 = x[SH_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  endfunction

endpackage

/* design/kce_intf.sv */
`timescale 1ns / 1ps
// Request and response channel interfaces for the keyframe curve evaluator.
// Depends on kce_pkg for field widths.
interface kce_req_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [3:0]                    key_slot;
  logic signed [kce_pkg::DW-1:0] key_time;
  logic signed [kce_pkg::DW-1:0] key_value;
  logic [1:0]                    interp_kind;
  logic                          tangent_kind;
  logic signed [kce_pkg::DW-1:0] arrive_slope;
  logic signed [kce_pkg::DW-1:0] leave_slope;
  logic signed [kce_pkg::DW-1:0] query_time;

  modport source (output valid, command, key_slot, key_time, key_value, interp_kind,
                  tangent_kind, arrive_slope, leave_slope, query_time, input ready);
  modport sink (input valid, command, key_slot, key_time, key_value, interp_kind,
                tangent_kind, arrive_slope, leave_slope, query_time, output ready);
endinterface

interface kce_rsp_if;
  logic                          valid;
  logic                          ready;
  logic signed [kce_pkg::DW-1:0] curve_value;
  logic signed [kce_pkg::DW-1:0] first_time;
  logic signed [kce_pkg::DW-1:0] last_time;

  modport source (output valid, curve_value, first_time, last_time, input ready);
  modport sink (input valid, curve_value, first_time, last_time, output ready);
endinterface

/* design/keyframe_curve_evaluator_unit.sv */
`timescale 1ns / 1ps
// Keyframe curve evaluator: key table memory, segment search, serial divider, Hermite MAC.
// Depends on kce_pkg and the kce_req_if / kce_rsp_if interfaces.
//
// One request at a time. An evaluate searches the single-port key memory for segment k,
// sets up the segment, then runs up to three divisions on the one-bit-per-cycle divider
// (segment position, leave tangent, arrive tangent) with tangent setup around each,
// then eight steps on the shared 34x34 multiplier for a cubic segment. A linear segment
// needs only the position division and one multiplier step; a constant or zero-length
// segment and a clamped query need neither.
// The result waits in an output register; the next request is taken once it is loaded.
module keyframe_curve_evaluator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kce_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kce_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  kce_req_if.sink                          req_i,
  kce_rsp_if.source                        rsp_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RDL   = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_SCAN  = 5'd3;
  localparam logic [4:0] S_SEG   = 5'd4;
  localparam logic [4:0] S_DIV   = 5'd5;
  localparam logic [4:0] S_ALPHA = 5'd6;
  localparam logic [4:0] S_TL    = 5'd7;
  localparam logic [4:0] S_TLN   = 5'd8;
  localparam logic [4:0] S_TLD   = 5'd9;
  localparam logic [4:0] S_TA    = 5'd10;
  localparam logic [4:0] S_TAN   = 5'd11;
  localparam logic [4:0] S_TAD   = 5'd12;
  localparam logic [4:0] S_MUL   = 5'd13;
  localparam logic [4:0] S_ACC   = 5'd14;
  localparam logic [4:0] S_DONE  = 5'd15;

  localparam logic [3:0] OP_LIN = 4'd0;
  localparam logic [3:0] OP_A2  = 4'd1;
  localparam logic [3:0] OP_A3  = 4'd2;
  localparam logic [3:0] OP_H00 = 4'd3;
  localparam logic [3:0] OP_H01 = 4'd4;
  localparam logic [3:0] OP_H10 = 4'd5;
  localparam logic [3:0] OP_TL  = 4'd6;
  localparam logic [3:0] OP_H11 = 4'd7;
  localparam logic [3:0] OP_TA  = 4'd8;

  kce_pkg::key_t key_mem [kce_pkg::MAX_KEYS];

  logic [4:0]                          state_q, state_d;
  logic [4:0]                          div_ret_q, div_ret;
  logic [kce_pkg::DCNT_W-1:0]          dcnt_q;
  logic                                rsp_valid_q;
  logic [kce_pkg::KEYS_W-1:0]          keys_q;
  logic [kce_pkg::NZ_W-1:0]            near_q;

  logic                                rd_en;
  logic [kce_pkg::SLOT_W-1:0]          rd_addr;
  kce_pkg::key_t                       rd_q;
  kce_pkg::key_t                       e0_q, e1_q, wr_key;

  logic signed [kce_pkg::DW-1:0]       q_q, res_q, first_q, last_q;
  logic signed [kce_pkg::DW-1:0]       out_val_q, out_first_q, out_last_q;
  logic [kce_pkg::SLOT_W-1:0]          k_q;
  logic [kce_pkg::CNT_W-1:0]           n_w;
  logic                                k2_in;
  logic                                done_free;
  logic                                eval_acc, write_acc;

  logic                                div_go;
  logic signed [kce_pkg::EXT_W-1:0]    div_dv, div_dt;
  logic [kce_pkg::NUM_W-1:0]           dnum_q, dquo_q;
  logic [kce_pkg::EXT_W-1:0]           dden_q;
  logic [kce_pkg::EXT_W:0]             drem_q, rem_sh;
  logic                                dneg_q, dbit;
  logic signed [kce_pkg::DW-1:0]       div_res;

  logic signed [kce_pkg::EXT_W-1:0]    len_w, dv01_w, qt0_w, dtn_w, dvn_w;
  logic [kce_pkg::AW-1:0]              alpha_q, a2_q, a3_q;
  logic signed [kce_pkg::HW-1:0]       h00_w, h01_w, h10_w, h11_w;
  logic signed [kce_pkg::DW-1:0]       ml_q, ma_q;
  logic [3:0]                          op_q;
  logic signed [kce_pkg::OPW-1:0]      mul_a, mul_b, tmp_q;
  logic signed [kce_pkg::PROD_W-1:0]   prod_q;
  logic signed [kce_pkg::SH_W-1:0]     sh_w;
  logic signed [kce_pkg::ACC_W-1:0]    acc_q;

  assign n_w = (32'(keys_q) > kce_pkg::MAX_KEYS) ? kce_pkg::CNT_W'(kce_pkg::MAX_KEYS)
                                                 : kce_pkg::CNT_W'(keys_q);
  assign k2_in     = ((kce_pkg::CNT_W + 1)'(k_q) + 2'd2) < (kce_pkg::CNT_W + 1)'(n_w);
  assign done_free = !rsp_valid_q || rsp_o.ready;
  assign eval_acc  = req_i.valid && req_i.ready && (req_i.command == kce_pkg::CMD_EVAL);
  assign write_acc = req_i.valid && req_i.ready && (req_i.command == kce_pkg::CMD_WRITE);

  assign len_w  = kce_pkg::EXT_W'(e1_q.t) - kce_pkg::EXT_W'(e0_q.t);
  assign dv01_w = kce_pkg::EXT_W'(e1_q.v) - kce_pkg::EXT_W'(e0_q.v);
  assign qt0_w  = kce_pkg::EXT_W'(q_q) - kce_pkg::EXT_W'(e0_q.t);
  assign dtn_w  = (state_q == S_TLN) ? kce_pkg::EXT_W'(e1_q.t) - kce_pkg::EXT_W'(rd_q.t)
                                     : kce_pkg::EXT_W'(rd_q.t) - kce_pkg::EXT_W'(e0_q.t);
  assign dvn_w  = (state_q == S_TLN) ? kce_pkg::EXT_W'(e1_q.v) - kce_pkg::EXT_W'(rd_q.v)
                                     : kce_pkg::EXT_W'(rd_q.v) - kce_pkg::EXT_W'(e0_q.v);

  assign h00_w = kce_pkg::HW'(2 * kce_pkg::HW'(a3_q) - 3 * kce_pkg::HW'(a2_q)
                              + kce_pkg::HW'(kce_pkg::ONE));
  assign h10_w = kce_pkg::HW'(kce_pkg::HW'(a3_q) - 2 * kce_pkg::HW'(a2_q)
                              + kce_pkg::HW'(alpha_q));
  assign h01_w = kce_pkg::HW'(3 * kce_pkg::HW'(a2_q) - 2 * kce_pkg::HW'(a3_q));
  assign h11_w = kce_pkg::HW'(a3_q) - kce_pkg::HW'(a2_q);

  assign sh_w    = kce_pkg::SH_W'(prod_q >>> kce_pkg::FRAC_BITS);
  assign rem_sh  = {drem_q[kce_pkg::EXT_W-1:0], dnum_q[kce_pkg::NUM_W-1]};
  assign dbit    = rem_sh >= {1'b0, dden_q};
  assign div_res = kce_pkg::sat_div(dquo_q, dneg_q);

  assign wr_key = '{t: req_i.key_time, v: req_i.key_value, interp: req_i.interp_kind,
                    tk: req_i.tangent_kind, arrive: req_i.arrive_slope,
                    leave: req_i.leave_slope};

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.curve_value = out_val_q;
  assign rsp_o.first_time  = out_first_q;
  assign rsp_o.last_time   = out_last_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      OP_LIN: begin
        mul_a = kce_pkg::OPW'(dv01_w);
        mul_b = kce_pkg::OPW'(alpha_q);
      end
      OP_A2: begin
        mul_a = kce_pkg::OPW'(alpha_q);
        mul_b = kce_pkg::OPW'(alpha_q);
      end
      OP_A3: begin
        mul_a = kce_pkg::OPW'(a2_q);
        mul_b = kce_pkg::OPW'(alpha_q);
      end
      OP_H00: begin
        mul_a = kce_pkg::OPW'(h00_w);
        mul_b = kce_pkg::OPW'(e0_q.v);
      end
      OP_H01: begin
        mul_a = kce_pkg::OPW'(h01_w);
        mul_b = kce_pkg::OPW'(e1_q.v);
      end
      OP_H10: begin
        mul_a = kce_pkg::OPW'(h10_w);
        mul_b = kce_pkg::OPW'(len_w);
      end
      OP_TL: begin
        mul_a = tmp_q;
        mul_b = kce_pkg::OPW'(ml_q);
      end
      OP_H11: begin
        mul_a = kce_pkg::OPW'(h11_w);
        mul_b = kce_pkg::OPW'(len_w);
      end
      OP_TA: begin
        mul_a = tmp_q;
        mul_b = kce_pkg::OPW'(ma_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    div_go  = 1'b0;
    div_dv  = dv01_w;
    div_dt  = len_w;
    div_ret = S_IDLE;
    case (state_q)
      S_IDLE: begin
        if (eval_acc) begin
          if (n_w != '0) begin
            rd_en   = 1'b1;
            state_d = S_RDL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RDL: begin
        rd_en   = 1'b1;
        rd_addr = kce_pkg::SLOT_W'(n_w - 1'b1);
        state_d = S_CHK;
      end
      S_CHK: begin
        if (q_q <= e0_q.t || q_q >= rd_q.t) begin
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = kce_pkg::SLOT_W'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (e0_q.t <= q_q && q_q <= rd_q.t) begin
          state_d = S_SEG;
        end else if (k2_in) begin
          rd_en   = 1'b1;
          rd_addr = k_q + kce_pkg::SLOT_W'(2);
        end else begin
          state_d = S_DONE;
        end
      end
      S_SEG: begin
        if (kce_pkg::near_zero(len_w, near_q) || e0_q.interp == kce_pkg::INTERP_CONST) begin
          state_d = S_DONE;
        end else begin
          div_go  = 1'b1;
          div_dv  = qt0_w;
          div_ret = S_ALPHA;
        end
      end
      S_DIV: begin
        if (dcnt_q == kce_pkg::DCNT_W'(1)) begin
          state_d = div_ret_q;
        end
      end
      S_ALPHA: begin
        state_d = (e0_q.interp == kce_pkg::INTERP_LINEAR) ? S_MUL : S_TL;
      end
      S_TL: begin
        if (e0_q.tk) begin
          state_d = S_TA;
        end else if (k_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = k_q - 1'b1;
          state_d = S_TLN;
        end else begin
          div_go  = 1'b1;
          div_ret = S_TLD;
        end
      end
      S_TLN: begin
        div_go  = 1'b1;
        div_ret = S_TLD;
        if (!kce_pkg::near_zero(dtn_w, near_q)) begin
          div_dv = dvn_w;
          div_dt = dtn_w;
        end
      end
      S_TLD: state_d = S_TA;
      S_TA: begin
        if (e1_q.tk) begin
          state_d = S_MUL;
        end else if (k2_in) begin
          rd_en   = 1'b1;
          rd_addr = k_q + kce_pkg::SLOT_W'(2);
          state_d = S_TAN;
        end else begin
          div_go  = 1'b1;
          div_ret = S_TAD;
        end
      end
      S_TAN: begin
        div_go  = 1'b1;
        div_ret = S_TAD;
        if (!kce_pkg::near_zero(dtn_w, near_q)) begin
          div_dv = dvn_w;
          div_dt = dtn_w;
        end
      end
      S_TAD: state_d = S_MUL;
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        state_d = (op_q == OP_LIN || op_q == OP_TA) ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (done_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (div_go) begin
      state_d = S_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_ret_q   <= S_IDLE;
      dcnt_q      <= '0;
      rsp_valid_q <= 1'b0;
      keys_q      <= '0;
      near_q      <= kce_pkg::NZ_W'(1);
    end else begin
      state_q <= state_d;
      if (div_go) begin
        div_ret_q <= div_ret;
        dcnt_q    <= kce_pkg::DCNT_W'(kce_pkg::NUM_W);
      end else if (state_q == S_DIV) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (state_q == S_DONE && done_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kce_pkg::CFG_KEYS_IN_USE: keys_q <= cfg_wdata_i[kce_pkg::KEYS_W-1:0];
          kce_pkg::CFG_NEAR_ZERO:   near_q <= cfg_wdata_i[kce_pkg::NZ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_acc && 32'(req_i.key_slot) < kce_pkg::MAX_KEYS) begin
      key_mem[kce_pkg::SLOT_W'(req_i.key_slot)] <= wr_key;
    end
    if (rd_en) begin
      rd_q <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_go) begin
      dnum_q <= {kce_pkg::mag(div_dv), kce_pkg::FRAC_BITS'(0)};
      dden_q <= kce_pkg::mag(div_dt);
      drem_q <= '0;
      dquo_q <= '0;
      dneg_q <= div_dv[kce_pkg::EXT_W-1] ^ div_dt[kce_pkg::EXT_W-1];
    end else if (state_q == S_DIV) begin
      dnum_q <= dnum_q << 1;
      drem_q <= dbit ? (rem_sh - {1'b0, dden_q}) : rem_sh;
      dquo_q <= {dquo_q[kce_pkg::NUM_W-2:0], dbit};
    end
    case (state_q)
      S_IDLE: begin
        if (eval_acc) begin
          q_q     <= req_i.query_time;
          k_q     <= '0;
          first_q <= '0;
          last_q  <= '0;
          res_q   <= '0;
        end
      end
      S_RDL: begin
        e0_q    <= rd_q;
        first_q <= rd_q.t;
      end
      S_CHK: begin
        last_q <= rd_q.t;
        res_q  <= (q_q <= e0_q.t) ? e0_q.v : rd_q.v;
      end
      S_SCAN: begin
        e1_q <= rd_q;
        if (!(e0_q.t <= q_q && q_q <= rd_q.t)) begin
          e0_q <= rd_q;
          k_q  <= k_q + 1'b1;
        end
      end
      S_SEG: res_q <= e0_q.v;
      S_ALPHA: begin
        alpha_q <= (dquo_q > kce_pkg::NUM_W'(kce_pkg::ONE)) ? kce_pkg::ONE
                                                            : dquo_q[kce_pkg::AW-1:0];
        op_q    <= (e0_q.interp == kce_pkg::INTERP_LINEAR) ? OP_LIN : OP_A2;
      end
      S_TL: begin
        if (e0_q.tk) begin
          ml_q <= e0_q.leave;
        end
      end
      S_TLD: ml_q <= div_res;
      S_TA: begin
        if (e1_q.tk) begin
          ma_q <= e1_q.arrive;
        end
      end
      S_TAD: ma_q <= div_res;
      S_MUL: prod_q <= mul_a * mul_b;
      S_ACC: begin
        op_q <= op_q + 1'b1;
        case (op_q)
          OP_LIN: res_q <= kce_pkg::sat32(kce_pkg::SH_W'(e0_q.v) + sh_w);
          OP_A2:  a2_q  <= sh_w[kce_pkg::AW-1:0];
          OP_A3:  a3_q  <= sh_w[kce_pkg::AW-1:0];
          OP_H00: acc_q <= kce_pkg::ACC_W'(sh_w);
          OP_H01: acc_q <= acc_q + kce_pkg::ACC_W'(sh_w);
          OP_H10: tmp_q <= kce_pkg::OPW'(sh_w);
          OP_TL:  acc_q <= acc_q + kce_pkg::ACC_W'(sh_w);
          OP_H11: tmp_q <= kce_pkg::OPW'(sh_w);
          OP_TA:  res_q <= kce_pkg::sat32(kce_pkg::SH_W'(acc_q) + sh_w);
          default: ;
        endcase
      end
      S_DONE: begin
        if (done_free) begin
          out_val_q   <= res_q;
          out_first_q <= first_q;
          out_last_q  <= last_q;
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/kce_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the keyframe curve evaluator, bound to the top level.
// Depends on kce_pkg.
module kce_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [kce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [kce_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           req_command,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [kce_pkg::DW-1:0]         rsp_curve_value,
  input logic [kce_pkg::DW-1:0]         rsp_first_time,
  input logic [kce_pkg::DW-1:0]         rsp_last_time
);

  logic [1:0]                 pend_q;
  logic [kce_pkg::KEYS_W-1:0] keys_q;
  logic                       eval_acc, rsp_acc;

  assign eval_acc = req_valid && req_ready && (req_command == kce_pkg::CMD_EVAL);
  assign rsp_acc  = rsp_valid && rsp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      keys_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(eval_acc) - 2'(rsp_acc);
      if (cfg_we_i && cfg_idx_i == kce_pkg::CFG_KEYS_IN_USE) begin
        keys_q <= cfg_wdata_i[kce_pkg::KEYS_W-1:0];
      end
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> pend_q != 2'd0)
    else $error("response without an evaluate request");

  a_one_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_acc |-> pend_q <= 2'd1)
    else $error("evaluate taken with two results outstanding");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && keys_q == '0 |->
      rsp_curve_value == '0 && rsp_first_time == '0 && rsp_last_time == '0)
    else $error("empty curve gave nonzero response");

  a_single_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && keys_q == kce_pkg::KEYS_W'(1) |-> rsp_first_time == rsp_last_time)
    else $error("single key with differing first and last times");

endmodule

bind keyframe_curve_evaluator_unit kce_checker u_kce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_idx_i       (cfg_idx_i),
  .cfg_wdata_i     (cfg_wdata_i),
  .req_valid       (req_i.valid),
  .req_ready       (req_i.ready),
  .req_command     (req_i.command),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .rsp_curve_value (rsp_o.curve_value),
  .rsp_first_time  (rsp_o.first_time),
  .rsp_last_time   (rsp_o.last_time)
);
